>>> rtl/cstt_pkg.sv
// Shared constants for the counted sequence type table.
`default_nettype none
package cstt_pkg;
    localparam int IDX_W  = 6;
    localparam int NODE_W = 16;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;
endpackage
`default_nettype wire

>>> rtl/cstt_ram.sv
// Single-port synchronous RAM, registered read.
`default_nettype none
module cstt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> rtl/counted_sequence_type_table_unit.sv
// Top level: sequencer over the type memory and the node list memory.
// One word at a time. An add walks the type memory until a match and then moves the tail
// of the node list up one place; with no match it appends a new type. A remove walks the
// types up to the named one to find its group, scans the group, moves the list tail down
// and, when the type empties, moves the later types down. Every path is bound by the single
// port of each memory. A result waits in an output register while the next word is taken.
// No clearing pass after reset.
`default_nettype none
module counted_sequence_type_table_unit #(
    parameter int MAX_TYPES = 64,
    parameter int SEQ_LEN   = 64,
    parameter int MAX_NODES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [63:0] sequence_req, [69:64] type_index, [85:70] node, [87:86] zero
    input  wire logic [87:0] i_s_tdata,
    // [0] kind
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [5:0] result_index, [6] type_changed, [8:7] status, [15:9] zero
    output logic      [15:0] o_m_tdata
);
    localparam int TIW  = $clog2(MAX_TYPES);
    localparam int TTW  = $clog2(MAX_TYPES + 1);
    localparam int NIW  = $clog2(MAX_NODES);
    localparam int NTW  = $clog2(MAX_NODES + 1);
    localparam int CW   = NTW;
    localparam int TWW  = SEQ_LEN + CW;
    localparam int CMPW = (TTW > cstt_pkg::IDX_W) ? TTW : cstt_pkg::IDX_W;

    typedef enum logic [4:0] {
        S_IDLE, S_T_RD, S_T_CHK, S_T_NEW, S_N_SHRD, S_N_SHWR, S_N_PUT,
        S_R_CRD, S_R_CCHK, S_R_SRD, S_R_SCHK, S_R_MVRD, S_R_MVWR, S_R_MVEND,
        S_T_DRD, S_T_DWR, S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [TIW-1:0]              r_i, n_i;
    logic [NIW-1:0]              r_j, n_j;
    logic [NTW-1:0]              r_acc, n_acc;
    logic [NTW-1:0]              r_stop, n_stop;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [SEQ_LEN-1:0]          r_seq, n_seq;
    logic [cstt_pkg::NODE_W-1:0] r_node, n_node;
    logic [cstt_pkg::IDX_W-1:0]  r_tidx, n_tidx;
    logic [TTW-1:0]              r_type_total, n_type_total;
    logic [NTW-1:0]              r_node_total, n_node_total;
    logic [cstt_pkg::IDX_W-1:0]  r_res_idx, n_res_idx;
    logic                        r_res_chg, n_res_chg;
    logic [1:0]                  r_res_st, n_res_st;
    logic                        r_out_valid, n_out_valid;
    logic [15:0]                 r_out_data, n_out_data;

    logic                        t_we, nd_we;
    logic [TIW-1:0]              t_addr;
    logic [NIW-1:0]              nd_addr;
    logic [TWW-1:0]              t_wdata, t_rdata;
    logic [cstt_pkg::NODE_W-1:0] nd_wdata, nd_rdata;

    logic [SEQ_LEN-1:0] rd_seq;
    logic [CW-1:0]      rd_cnt;
    logic [NTW:0]       grp_end;
    logic [NTW-1:0]     grp_stop;
    logic               accept;

    cstt_ram #(.DEPTH(MAX_TYPES), .WIDTH(TWW)) u_type_ram (
        .i_clk(i_clk), .i_we(t_we), .i_addr(t_addr),
        .i_wdata(t_wdata), .o_rdata(t_rdata)
    );

    cstt_ram #(.DEPTH(MAX_NODES), .WIDTH(cstt_pkg::NODE_W)) u_node_ram (
        .i_clk(i_clk), .i_we(nd_we), .i_addr(nd_addr),
        .i_wdata(nd_wdata), .o_rdata(nd_rdata)
    );

    assign rd_seq   = t_rdata[TWW-1:CW];
    assign rd_cnt   = t_rdata[CW-1:0];
    assign grp_end  = {1'b0, r_acc} + (NTW+1)'(rd_cnt);
    assign grp_stop = (grp_end > (NTW+1)'(r_node_total)) ? r_node_total : NTW'(grp_end);
    assign accept   = i_s_tvalid && o_s_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state      = r_state;
        n_i          = r_i;
        n_j          = r_j;
        n_acc        = r_acc;
        n_stop       = r_stop;
        n_cnt        = r_cnt;
        n_seq        = r_seq;
        n_node       = r_node;
        n_tidx       = r_tidx;
        n_type_total = r_type_total;
        n_node_total = r_node_total;
        n_res_idx    = r_res_idx;
        n_res_chg    = r_res_chg;
        n_res_st     = r_res_st;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_data   = r_out_data;
        t_we     = 1'b0;
        t_addr   = r_i;
        t_wdata  = {r_seq, r_cnt};
        nd_we    = 1'b0;
        nd_addr  = r_j;
        nd_wdata = r_node;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_seq     = i_s_tdata[SEQ_LEN-1:0];
                    n_tidx    = i_s_tdata[69:64];
                    n_node    = i_s_tdata[85:70];
                    n_i       = '0;
                    n_acc     = '0;
                    n_res_chg = 1'b0;
                    n_res_st  = cstt_pkg::ST_OK;
                    if (i_s_tuser == cstt_pkg::KIND_ADD) begin
                        n_res_idx = '0;
                        if (r_node_total == NTW'(MAX_NODES)) begin
                            n_res_st = cstt_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else if (r_type_total == '0) begin
                            n_state = S_T_NEW;
                        end else begin
                            n_state = S_T_RD;
                        end
                    end else begin
                        n_res_idx = i_s_tdata[69:64];
                        if (CMPW'(i_s_tdata[69:64]) >= CMPW'(r_type_total)) begin
                            n_res_st = cstt_pkg::ST_BAD_INDEX;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_R_CRD;
                        end
                    end
                end
            end
            S_T_RD: begin
                n_state = S_T_CHK;
            end
            S_T_CHK: begin
                if (rd_seq == r_seq) begin
                    // bump count now, the port is free this cycle
                    t_we      = 1'b1;
                    t_wdata   = {r_seq, rd_cnt + CW'(1)};
                    n_stop    = grp_stop;
                    n_j       = NIW'(r_node_total);
                    n_res_idx = cstt_pkg::IDX_W'(r_i);
                    n_state   = (r_node_total > grp_stop) ? S_N_SHRD : S_N_PUT;
                end else begin
                    n_acc = NTW'(grp_end);
                    n_i   = r_i + TIW'(1);
                    n_state = (TTW'(r_i) + TTW'(1) == r_type_total) ? S_T_NEW : S_T_RD;
                end
            end
            S_T_NEW: begin
                if (r_type_total == TTW'(MAX_TYPES)) begin
                    n_res_st  = cstt_pkg::ST_FULL;
                    n_res_idx = '0;
                    n_state   = S_DONE;
                end else begin
                    t_we         = 1'b1;
                    t_addr       = TIW'(r_type_total);
                    t_wdata      = {r_seq, CW'(1)};
                    n_res_idx    = cstt_pkg::IDX_W'(r_type_total);
                    n_res_chg    = 1'b1;
                    n_type_total = r_type_total + TTW'(1);
                    n_stop       = r_node_total;
                    n_state      = S_N_PUT;
                end
            end
            S_N_SHRD: begin
                nd_addr = r_j - NIW'(1);
                n_state = S_N_SHWR;
            end
            S_N_SHWR: begin
                nd_we    = 1'b1;
                nd_wdata = nd_rdata;
                n_j      = r_j - NIW'(1);
                n_state  = (NTW'(r_j) - NTW'(1) == r_stop) ? S_N_PUT : S_N_SHRD;
            end
            S_N_PUT: begin
                nd_we        = 1'b1;
                nd_addr      = NIW'(r_stop);
                n_node_total = r_node_total + NTW'(1);
                n_state      = S_DONE;
            end
            S_R_CRD: begin
                n_state = S_R_CCHK;
            end
            S_R_CCHK: begin
                if (cstt_pkg::IDX_W'(r_i) == r_tidx && CMPW'(r_i) == CMPW'(r_tidx)) begin
                    n_cnt  = rd_cnt;
                    n_seq  = rd_seq;
                    n_stop = grp_stop;
                    n_j    = NIW'(r_acc);
                    if (r_acc >= grp_stop) begin
                        n_res_st = cstt_pkg::ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_R_SRD;
                    end
                end else begin
                    n_acc   = NTW'(grp_end);
                    n_i     = r_i + TIW'(1);
                    n_state = S_R_CRD;
                end
            end
            S_R_SRD: begin
                n_state = S_R_SCHK;
            end
            S_R_SCHK: begin
                if (nd_rdata == r_node) begin
                    n_state = (NTW'(r_j) + NTW'(1) < r_node_total) ? S_R_MVRD : S_R_MVEND;
                end else if (NTW'(r_j) + NTW'(1) >= r_stop) begin
                    n_res_st = cstt_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_j     = r_j + NIW'(1);
                    n_state = S_R_SRD;
                end
            end
            S_R_MVRD: begin
                nd_addr = r_j + NIW'(1);
                n_state = S_R_MVWR;
            end
            S_R_MVWR: begin
                nd_we    = 1'b1;
                nd_wdata = nd_rdata;
                n_j      = r_j + NIW'(1);
                n_state  = (NTW'(r_j) + NTW'(2) < r_node_total) ? S_R_MVRD : S_R_MVEND;
            end
            S_R_MVEND: begin
                n_node_total = r_node_total - NTW'(1);
                if (r_cnt > CW'(1)) begin
                    t_we    = 1'b1;
                    t_wdata = {r_seq, r_cnt - CW'(1)};
                    n_state = S_DONE;
                end else if (TTW'(r_i) + TTW'(1) < r_type_total) begin
                    n_res_chg = 1'b1;
                    n_state   = S_T_DRD;
                end else begin
                    n_res_chg    = 1'b1;
                    n_type_total = r_type_total - TTW'(1);
                    n_state      = S_DONE;
                end
            end
            S_T_DRD: begin
                t_addr  = r_i + TIW'(1);
                n_state = S_T_DWR;
            end
            S_T_DWR: begin
                t_we    = 1'b1;
                t_wdata = t_rdata;
                n_i     = r_i + TIW'(1);
                if (TTW'(r_i) + TTW'(2) < r_type_total) begin
                    n_state = S_T_DRD;
                end else begin
                    n_type_total = r_type_total - TTW'(1);
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_res_st, r_res_chg, r_res_idx};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_type_total <= '0;
            r_node_total <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_type_total <= n_type_total;
            r_node_total <= n_node_total;
            r_out_valid  <= n_out_valid;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_acc      <= n_acc;
        r_stop     <= n_stop;
        r_cnt      <= n_cnt;
        r_seq      <= n_seq;
        r_node     <= n_node;
        r_tidx     <= n_tidx;
        r_res_idx  <= n_res_idx;
        r_res_chg  <= n_res_chg;
        r_res_st   <= n_res_st;
        r_out_data <= n_out_data;
    end

    // every live type owns at least one node; totals settle by the time we idle
    a_types_le_nodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_type_total) <= 32'(r_node_total)))
        else $error("type total exceeds node total");

    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_total <= NTW'(MAX_NODES) && r_type_total <= TTW'(MAX_TYPES))
        else $error("table total out of range");

    // a result with a type change always moves the type total
    a_chg_moves_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_chg) |-> (r_type_total != $past(r_type_total, 2)
            || $past(r_state) == S_DONE))
        else $error("type change without total update");
endmodule
`default_nettype wire

>>> tb/tb_counted_sequence_type_table_unit.sv
// Testbench for the counted sequence type table: directed and random add/remove words checked by a scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_counted_sequence_type_table_unit;
    localparam int NTYPES = 64;
    localparam int NNODES = 256;

    class type_table_board;
        logic [63:0] seqs[NTYPES];
        int          counts[NTYPES];
        int          ntypes;
        logic [15:0] nodes[NNODES];
        int          nnodes;
        logic [8:0]  pending[$];
        int          errors;

        function new();
            ntypes = 0;
            nnodes = 0;
            errors = 0;
        endfunction

        function logic [8:0] pack(int idx, bit chg, logic [1:0] st);
            return {st, chg, idx[5:0]};
        endfunction

        function logic [8:0] predict_add(logic [63:0] sq, logic [15:0] nd);
            int e;
            int c;
            bit hit;
            e = 0;
            c = 0;
            hit = 0;
            if (nnodes >= NNODES) return pack(0, 1'b0, cstt_pkg::ST_FULL);
            for (int i = 0; i < ntypes; i++) begin
                e += counts[i];
                if (seqs[i] == sq) begin
                    c = i;
                    hit = 1;
                    break;
                end
            end
            if (hit) begin
                if (e > nnodes) e = nnodes;
                counts[c]++;
                for (int i = nnodes; i > e; i--) nodes[i] = nodes[i-1];
                nodes[e] = nd;
                nnodes++;
                return pack(c, 1'b0, cstt_pkg::ST_OK);
            end
            if (ntypes >= NTYPES) return pack(0, 1'b0, cstt_pkg::ST_FULL);
            seqs[ntypes] = sq;
            counts[ntypes] = 1;
            nodes[nnodes] = nd;
            nnodes++;
            ntypes++;
            return pack(ntypes - 1, 1'b1, cstt_pkg::ST_OK);
        endfunction

        function logic [8:0] predict_remove(int c, logic [15:0] nd);
            int s;
            int p;
            bit hit;
            s = 0;
            p = 0;
            hit = 0;
            if (c >= ntypes) return pack(c, 1'b0, cstt_pkg::ST_BAD_INDEX);
            for (int i = 0; i < c; i++) s += counts[i];
            for (int i = s; i < s + counts[c] && i < nnodes; i++)
                if (nodes[i] == nd) begin
                    p = i;
                    hit = 1;
                    break;
                end
            if (!hit) return pack(c, 1'b0, cstt_pkg::ST_NOT_FOUND);
            for (int i = p; i + 1 < nnodes; i++) nodes[i] = nodes[i+1];
            nnodes--;
            if (counts[c] > 1) begin
                counts[c]--;
                return pack(c, 1'b0, cstt_pkg::ST_OK);
            end
            for (int i = c; i + 1 < ntypes; i++) begin
                seqs[i] = seqs[i+1];
                counts[i] = counts[i+1];
            end
            ntypes--;
            return pack(c, 1'b1, cstt_pkg::ST_OK);
        endfunction

        function void note_word(logic kind, logic [63:0] sq, logic [5:0] ti, logic [15:0] nd);
            if (kind == cstt_pkg::KIND_ADD) pending.push_back(predict_add(sq, nd));
            else pending.push_back(predict_remove(int'(ti), nd));
        endfunction

        function void check_word(logic [15:0] got);
            logic [8:0] x;
            if (pending.size() == 0) begin
                $error("unexpected result word %h", got);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got[5:0] !== x[5:0]) begin
                $error("result_index exp %0d got %0d", x[5:0], got[5:0]);
                errors++;
            end
            if (got[6] !== x[6]) begin
                $error("type_changed exp %0d got %0d", x[6], got[6]);
                errors++;
            end
            if (got[8:7] !== x[8:7]) begin
                $error("status exp %0d got %0d", x[8:7], got[8:7]);
                errors++;
            end
            if (got[15:9] !== 7'd0) begin
                $error("pad exp 0 got %0h", got[15:9]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [87:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;

    type_table_board board;
    logic [63:0] seq_pool[8];

    counted_sequence_type_table_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("*** FAILED ***");
        $finish;
    end

    // One word on the slave side; the scoreboard learns it at acceptance.
    task automatic send_word(logic kind, logic [63:0] sq, logic [5:0] ti, logic [15:0] nd);
        int gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tuser  = kind;
        i_s_tdata  = {2'b00, nd, ti, sq};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_word(kind, sq, ti, nd);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain_all();
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    // Pick a node actually held by a type so removes mostly succeed.
    task automatic send_remove_hit();
        int c;
        int s;
        if (board.ntypes == 0) begin
            send_word(cstt_pkg::KIND_REMOVE, {$urandom(), $urandom()}, 6'($urandom()),
                      16'($urandom()));
            return;
        end
        c = $urandom_range(0, board.ntypes - 1);
        s = 0;
        for (int i = 0; i < c; i++) s += board.counts[i];
        s += $urandom_range(0, board.counts[c] - 1);
        send_word(cstt_pkg::KIND_REMOVE, {$urandom(), $urandom()}, 6'(c), board.nodes[s]);
    endtask

    // Master side: wait a drawn number of cycles per word, then take it.
    initial begin
        int w;
        i_m_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            w = $urandom_range(0, 16);
            if (w > 0) begin
                i_m_tready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check_word(o_m_tdata);

    initial begin
        logic [63:0] sq;
        int r;
        board = new();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = cstt_pkg::KIND_ADD;
        for (int i = 0; i < 8; i++) seq_pool[i] = {$urandom(), $urandom()};
        seq_pool[0] = '0;
        seq_pool[1] = '1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty-table removes, extremes, duplicates, miss, delete.
        send_word(cstt_pkg::KIND_REMOVE, '0, 6'd0, 16'd0);
        send_word(cstt_pkg::KIND_REMOVE, '1, 6'd63, 16'hffff);
        send_word(cstt_pkg::KIND_ADD, '0, 6'd0, 16'd0);
        send_word(cstt_pkg::KIND_ADD, '1, 6'd63, 16'hffff);
        send_word(cstt_pkg::KIND_ADD, '0, 6'd5, 16'h1234);
        send_word(cstt_pkg::KIND_ADD, '1, 6'd0, 16'hffff);
        send_word(cstt_pkg::KIND_REMOVE, '0, 6'd0, 16'hbeef);
        send_word(cstt_pkg::KIND_REMOVE, '0, 6'd2, 16'd1);
        send_word(cstt_pkg::KIND_REMOVE, '0, 6'd1, 16'hffff);
        send_word(cstt_pkg::KIND_REMOVE, '0, 6'd0, 16'd0);
        send_word(cstt_pkg::KIND_REMOVE, '0, 6'd0, 16'h1234);
        send_word(cstt_pkg::KIND_REMOVE, '0, 6'd0, 16'hffff);
        send_word(cstt_pkg::KIND_REMOVE, '0, 6'd0, 16'hffff);
        drain_all();

        // Fill the type table past its limit.
        for (int i = 0; i < 66; i++)
            send_word(cstt_pkg::KIND_ADD, {$urandom(), $urandom()}, 6'd0, 16'(i));
        drain_all();
        // Drop every type again, picking held nodes of random types.
        while (board.ntypes > 0) send_remove_hit();
        drain_all();
        // Fill the node list past its limit on four types.
        for (int i = 0; i < 260; i++)
            send_word(cstt_pkg::KIND_ADD, seq_pool[$urandom_range(0, 3)], 6'($urandom()),
                      16'($urandom()));
        drain_all();
        while (board.nnodes > 20) send_remove_hit();

        for (int n = 0; n < 200; n++) begin
            r = $urandom_range(0, 19);
            if (r < 9) begin
                sq = (r < 6) ? seq_pool[$urandom_range(0, 7)] : {$urandom(), $urandom()};
                send_word(cstt_pkg::KIND_ADD, sq, 6'($urandom()),
                          16'($urandom_range(0, 15)));
            end else if (r < 17) begin
                send_remove_hit();
            end else if (r < 19) begin
                send_word(cstt_pkg::KIND_REMOVE, {$urandom(), $urandom()}, 6'($urandom()),
                          16'($urandom()));
            end else begin
                send_word(cstt_pkg::KIND_REMOVE, '0, 6'($urandom_range(0, 3)),
                          16'($urandom_range(0, 15)));
            end
            if (n == 100) drain_all();
        end
        drain_all();
        repeat (2000) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
